>>> hdl/tti_pkg.sv
`timescale 1ns / 1ps
// tti_pkg: shared constants, thermistor reading table and divider handshake types
// for the thermistor table interpolator; no dependencies

package tti_pkg;

  localparam int ADC_W      = 10;
  localparam int ADC_MAX    = 1023;
  localparam int CODE_W     = 10;
  localparam int FAULT_W    = 2;
  localparam int TENTHS     = 10;
  // (prev - avg) * 10 stays below 2^14
  localparam int FRAC_NUM_W = ADC_W + 4;
  localparam int FRAC_W     = 4;

  localparam int ROM_SIZE = 80;
  localparam int IDX_W    = $clog2(ROM_SIZE);
  localparam int MAX_CODE = ROM_SIZE * TENTHS;

  localparam int DEF_SAMPLES_PER_RESULT = 32;
  localparam int DEF_TABLE_ENTRIES      = 80;

  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_HIGH = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_LOW  = 2'd2;

  // expected converter reading per table step, falling with the index
  localparam logic [ADC_W-1:0] RT_ROM [ROM_SIZE] = '{
    10'd923, 10'd918, 10'd913, 10'd907, 10'd901, 10'd895, 10'd888, 10'd882, 10'd875, 10'd868,
    10'd861, 10'd853, 10'd845, 10'd837, 10'd829, 10'd821, 10'd812, 10'd803, 10'd794, 10'd785,
    10'd775, 10'd766, 10'd755, 10'd746, 10'd735, 10'd725, 10'd715, 10'd704, 10'd693, 10'd682,
    10'd671, 10'd660, 10'd649, 10'd637, 10'd626, 10'd615, 10'd603, 10'd592, 10'd580, 10'd569,
    10'd557, 10'd546, 10'd534, 10'd523, 10'd512, 10'd500, 10'd489, 10'd478, 10'd467, 10'd456,
    10'd445, 10'd435, 10'd424, 10'd414, 10'd403, 10'd393, 10'd383, 10'd373, 10'd364, 10'd354,
    10'd345, 10'd336, 10'd327, 10'd318, 10'd310, 10'd301, 10'd293, 10'd285, 10'd277, 10'd269,
    10'd262, 10'd255, 10'd247, 10'd240, 10'd234, 10'd227, 10'd221, 10'd214, 10'd208, 10'd198
  };

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> hdl/tti_divider.sv
`timescale 1ns / 1ps
// tti_divider: restoring divider, one quotient bit per cycle
// depends on tti_pkg for the request and status structs

module tti_divider #(
  parameter int DW = 18,
  parameter int VW = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tti_pkg::div_req_t  req,
  input  logic [DW-1:0]      dividend,
  input  logic [VW-1:0]      divisor,
  output tti_pkg::div_sts_t  sts,
  output logic [DW-1:0]      quotient
);
  import tti_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [VW:0]   rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem_r[VW-1:0], quo_r[DW-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub : rem_sh;
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/thermistor_table_interpolator.sv
`timescale 1ns / 1ps
// thermistor_table_interpolator: sample averaging, table search and linear interpolation
// depends on tti_pkg and tti_divider
//
//  channel  direction  handshake              payload
//  in_      request    in_valid / in_stall    in_adc_sample
//  out_     result     out_valid / out_stall  out_temperature_code, out_range_fault
//
// samples are summed while in_stall is low; the last sample of a group starts a conversion
// made of the one-entry-a-cycle table search and the bit-serial divider for the tenths;
// the group average is one reciprocal multiply
// in_stall is high during the conversion and while a finished result waits for
// the output register to free up
// synchronous active-low reset clears the group sum, count and output valid

module thermistor_table_interpolator #(
  parameter int SAMPLES_PER_RESULT = tti_pkg::DEF_SAMPLES_PER_RESULT,
  parameter int TABLE_ENTRIES      = tti_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tti_pkg::ADC_W-1:0]    in_adc_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tti_pkg::CODE_W-1:0]   out_temperature_code,
  output logic [tti_pkg::FAULT_W-1:0]  out_range_fault
);
  import tti_pkg::*;

  localparam int SUM_W  = $clog2(ADC_MAX * SAMPLES_PER_RESULT + 1);
  localparam int CNT_W  = $clog2(SAMPLES_PER_RESULT);
  localparam int N_USED = (TABLE_ENTRIES > ROM_SIZE) ? ROM_SIZE : TABLE_ENTRIES;
  localparam int DW     = FRAC_NUM_W;
  localparam int VW     = ADC_W;
  localparam int PROD_W = IDX_W + 4;

  // average = (sum * AVG_RECIP) >> AVG_SH, exact for every sum below 2^SUM_W
  localparam int     AVG_SH      = SUM_W + $clog2(SAMPLES_PER_RESULT);
  localparam int     RECIP_W     = SUM_W + 1;
  localparam int     AVG_PROD_W  = SUM_W + RECIP_W;
  localparam longint AVG_RECIP_L = ((longint'(1) << AVG_SH) / longint'(SAMPLES_PER_RESULT)) + 1;
  localparam logic [RECIP_W-1:0] AVG_RECIP = RECIP_W'(AVG_RECIP_L);

  localparam logic [2:0] ST_ACC    = 3'd0;
  localparam logic [2:0] ST_AVG    = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_FRAC   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADC_W-1:0]      avg_r, avg_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [ADC_W-1:0]      prev_r, prev_nxt;
  logic [ADC_W-1:0]      diff_r, diff_nxt;
  logic [ADC_W-1:0]      den_r, den_nxt;
  logic [CODE_W-1:0]     res_code_r, res_code_nxt;
  logic [FAULT_W-1:0]    res_fault_r, res_fault_nxt;
  logic                  start_r, start_nxt;
  logic [DW-1:0]         div_dividend_r, div_dividend_nxt;
  logic [VW-1:0]         div_divisor_r, div_divisor_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]     out_code_r, out_code_nxt;
  logic [FAULT_W-1:0]    out_fault_r, out_fault_nxt;

  logic                  in_take;
  logic [SUM_W-1:0]      sum_plus;
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [ADC_W-1:0]      rom_cur;
  logic [FRAC_NUM_W-1:0] frac_num;
  logic [PROD_W-1:0]     idx_x10;
  div_req_t              div_req;
  div_sts_t              div_sts;
  logic [DW-1:0]         div_quo;

  assign in_stall = (state_r != ST_ACC);
  assign in_take  = in_valid && !in_stall;
  assign sum_plus = sum_r + SUM_W'(in_adc_sample);
  assign avg_prod = AVG_PROD_W'(sum_r) * AVG_PROD_W'(AVG_RECIP);
  assign rom_cur  = RT_ROM[idx_r];
  assign frac_num = (FRAC_NUM_W'(diff_r) << 3) + (FRAC_NUM_W'(diff_r) << 1);
  assign idx_x10  = (PROD_W'(idx_r) << 3) + (PROD_W'(idx_r) << 1);
  assign div_req.start = start_r;

  tti_divider #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend_r),
    .divisor  (div_divisor_r),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt        = state_r;
    sum_nxt          = sum_r;
    count_nxt        = count_r;
    avg_nxt          = avg_r;
    idx_nxt          = idx_r;
    prev_nxt         = prev_r;
    diff_nxt         = diff_r;
    den_nxt          = den_r;
    res_code_nxt     = res_code_r;
    res_fault_nxt    = res_fault_r;
    start_nxt        = 1'b0;
    div_dividend_nxt = div_dividend_r;
    div_divisor_nxt  = div_divisor_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_code_nxt     = out_code_r;
    out_fault_nxt    = out_fault_r;

    unique case (state_r)
      ST_ACC: begin
        if (in_take) begin
          sum_nxt = sum_plus;
          if (count_r == CNT_W'(SAMPLES_PER_RESULT - 1)) begin
            count_nxt = '0;
            state_nxt = ST_AVG;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      ST_AVG: begin
        avg_nxt   = ADC_W'(avg_prod >> AVG_SH);
        sum_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (avg_r >= rom_cur) begin
          if (idx_r == '0) begin
            // above the first entry is out of range, equal to it is the first step
            if (avg_r > rom_cur) begin
              res_code_nxt  = '0;
              res_fault_nxt = FAULT_HIGH;
            end else begin
              res_code_nxt  = CODE_W'(TENTHS);
              res_fault_nxt = FAULT_NONE;
            end
            state_nxt = ST_EMIT;
          end else begin
            diff_nxt  = prev_r - avg_r;
            den_nxt   = prev_r - rom_cur;
            state_nxt = ST_MUL;
          end
        end else if (idx_r == IDX_W'(N_USED - 1)) begin
          res_code_nxt  = '0;
          res_fault_nxt = FAULT_LOW;
          state_nxt     = ST_EMIT;
        end else begin
          prev_nxt = rom_cur;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      ST_MUL: begin
        if (den_r == '0) begin
          // flat table step: no tenths
          res_code_nxt  = idx_x10[CODE_W-1:0];
          res_fault_nxt = FAULT_NONE;
          state_nxt     = ST_EMIT;
        end else begin
          div_dividend_nxt = DW'(frac_num);
          div_divisor_nxt  = VW'(den_r);
          start_nxt        = 1'b1;
          state_nxt        = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (div_sts.done && !div_sts.busy) begin
          res_code_nxt  = CODE_W'(idx_x10 + PROD_W'(div_quo[FRAC_W-1:0]));
          res_fault_nxt = FAULT_NONE;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = res_code_r;
          out_fault_nxt = res_fault_r;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      sum_r       <= '0;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    avg_r          <= avg_nxt;
    idx_r          <= idx_nxt;
    prev_r         <= prev_nxt;
    diff_r         <= diff_nxt;
    den_r          <= den_nxt;
    res_code_r     <= res_code_nxt;
    res_fault_r    <= res_fault_nxt;
    div_dividend_r <= div_dividend_nxt;
    div_divisor_r  <= div_divisor_nxt;
    out_code_r     <= out_code_nxt;
    out_fault_r    <= out_fault_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_temperature_code = out_code_r;
  assign out_range_fault      = out_fault_r;

endmodule

>>> hdl/tti_checker.sv
`timescale 1ns / 1ps
// tti_checker: port-level checks on the thermistor table interpolator
// depends on tti_pkg; bound to thermistor_table_interpolator below

module tti_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [tti_pkg::ADC_W-1:0]    in_adc_sample,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tti_pkg::CODE_W-1:0]   out_temperature_code,
  input logic [tti_pkg::FAULT_W-1:0]  out_range_fault
);
  import tti_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_temperature_code) && $stable(out_range_fault))
    else $error("stalled result changed");

  // a range fault always carries a zero code
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_range_fault == FAULT_HIGH || out_range_fault == FAULT_LOW)
      |-> out_temperature_code == '0)
    else $error("fault with nonzero code");

  // in range codes lie between the first step and the table end
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_fault == FAULT_NONE
      |-> out_temperature_code >= CODE_W'(TENTHS) && out_temperature_code <= CODE_W'(MAX_CODE))
    else $error("in range code out of bounds");

  // a request taken as the stall drops carries a known sample
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && $past(in_stall) |-> !$isunknown(in_adc_sample))
    else $error("unknown sample accepted");

endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .in_adc_sample        (in_adc_sample),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_temperature_code (out_temperature_code),
  .out_range_fault      (out_range_fault)
);
